### rtl/core/fbpa_pkg.sv
// ----------------------------------------------------------------------------
// Fixed block pool allocator: shared package
// Codes, field widths, register indexes and the command/status bundles that
// pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package fbpa_pkg;

	// Default sizing handed to the top level parameters
	localparam int DEF_CAPACITY      = 1024;
	localparam int DEF_ADDRESS_WIDTH = 32;

	// Field and register widths
	localparam int OP_W        = 2;
	localparam int REL_W       = 32;
	localparam int OUT_W       = 32;
	localparam int STATUS_W    = 3;
	localparam int BASE_W      = 32;
	localparam int CHUNK_W     = 16;
	localparam int ENTRIES_W   = 11;
	localparam int MODE_W      = 2;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 32;

	// Rounded chunk is one bit wider so 65535 rounds up without wrapping
	localparam int                   RCHUNK_W         = CHUNK_W + 1;
	localparam logic [RCHUNK_W-1:0]  CHUNK_ALIGN_ADD  = RCHUNK_W'(3);
	localparam logic [RCHUNK_W-1:0]  CHUNK_ALIGN_MASK = ~RCHUNK_W'(3);

	// Configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] CFG_BASE    = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_CHUNK   = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_ENTRIES = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_MODE    = 2'd3;

	// Configuration reset values
	localparam logic [BASE_W-1:0]    BASE_RST    = '0;
	localparam logic [CHUNK_W-1:0]   CHUNK_RST   = CHUNK_W'(4);
	localparam logic [ENTRIES_W-1:0] ENTRIES_RST = '0;
	localparam logic [MODE_W-1:0]    MODE_RST    = '0;

	// Pool modes; everything but loop behaves as static
	localparam logic [MODE_W-1:0] MODE_LOOP = 2'd1;

	// Generation tag kept beside each stack entry; zero means never written
	localparam int                  EPOCH_W     = 8;
	localparam logic [EPOCH_W-1:0]  EPOCH_FIRST = EPOCH_W'(1);
	localparam logic [EPOCH_W-1:0]  EPOCH_LAST  = '1;

	typedef enum logic [OP_W-1:0] {
		OP_ALLOC   = 2'd0,
		OP_RELEASE = 2'd1,
		OP_RESTART = 2'd2,
		OP_NOP     = 2'd3
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK           = 3'd0,
		ST_EXHAUSTED    = 3'd1,
		ST_WRAPPED      = 3'd2,
		ST_IGNORED      = 3'd3,
		ST_UNDERFLOW    = 3'd4,
		ST_UNCONFIGURED = 3'd5
	} status_t;

	// Controller to datapath
	typedef struct packed {
		logic    load_item;     // capture the request beat
		logic    rd_en;         // read a stack entry, start the default address multiply
		logic    rd_zero;       // read entry 0 instead of the entry at the count
		logic    cnt_inc;
		logic    cnt_one;
		logic    cnt_clear;
		logic    wr_push;       // write the released address below the count, count - 1
		logic    epoch_next;
		logic    clr_write;     // one step of the tag clearing sweep
		logic    res_set;       // result status with a zero address
		status_t res_status;
		logic    res_addr_load; // result address from the fetched entry
		logic    out_load;      // move the result into the output register
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		op_t  op;
		logic alloc_unconf;
		logic alloc_avail;
		logic loop_mode;
		logic rel_null;
		logic count_zero;
		logic epoch_last;
		logic clr_last;
		logic out_busy;
	} dp_stat_t;

endpackage

### rtl/core/fbpa_ram.sv
// ----------------------------------------------------------------------------
// Fixed block pool allocator: generic RAM
// One write port, one read port, registered read data, no reset.
// ----------------------------------------------------------------------------
module fbpa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### rtl/core/fbpa_ctrl.sv
// ----------------------------------------------------------------------------
// Fixed block pool allocator: controller
// Sequences one request at a time through decide, fetch and finish, and runs
// the tag clearing sweep after reset and on generation wrap.
// ----------------------------------------------------------------------------
module fbpa_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  fbpa_pkg::dp_stat_t stat,
	output fbpa_pkg::dp_cmd_t  cmd
);

	import fbpa_pkg::*;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_DECIDE,
		S_FETCH,
		S_FINISH
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   clear_pend_q;
	logic   set_pend;

	assign req_stall = (state_q != S_IDLE);

	// Next state and datapath commands
	always_comb begin
		cmd            = '0;
		cmd.res_status = ST_OK;
		state_d        = state_q;
		set_pend       = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr_write = 1'b1;
				if (stat.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (req_valid) begin
					cmd.load_item = 1'b1;
					state_d       = S_DECIDE;
				end
			end
			S_DECIDE: begin
				state_d = S_FINISH;
				unique case (stat.op)
					OP_ALLOC: begin
						if (stat.alloc_unconf) begin
							cmd.res_set    = 1'b1;
							cmd.res_status = ST_UNCONFIGURED;
						end else if (stat.alloc_avail) begin
							cmd.rd_en      = 1'b1;
							cmd.cnt_inc    = 1'b1;
							cmd.res_set    = 1'b1;
							cmd.res_status = ST_OK;
							state_d        = S_FETCH;
						end else if (stat.loop_mode) begin
							cmd.rd_en      = 1'b1;
							cmd.rd_zero    = 1'b1;
							cmd.cnt_one    = 1'b1;
							cmd.res_set    = 1'b1;
							cmd.res_status = ST_WRAPPED;
							state_d        = S_FETCH;
						end else begin
							cmd.res_set    = 1'b1;
							cmd.res_status = ST_EXHAUSTED;
						end
					end
					OP_RELEASE: begin
						cmd.res_set = 1'b1;
						if (stat.rel_null || stat.loop_mode) begin
							cmd.res_status = ST_IGNORED;
						end else if (stat.count_zero) begin
							cmd.res_status = ST_UNDERFLOW;
						end else begin
							cmd.wr_push    = 1'b1;
							cmd.res_status = ST_OK;
						end
					end
					OP_RESTART: begin
						cmd.res_set    = 1'b1;
						cmd.res_status = ST_OK;
						cmd.cnt_clear  = 1'b1;
						cmd.epoch_next = 1'b1;
						set_pend       = stat.epoch_last;
					end
					OP_NOP: begin
						cmd.res_set    = 1'b1;
						cmd.res_status = ST_IGNORED;
					end
				endcase
			end
			S_FETCH: begin
				cmd.res_addr_load = 1'b1;
				state_d           = S_FINISH;
			end
			S_FINISH: begin
				if (!stat.out_busy) begin
					cmd.out_load = 1'b1;
					state_d      = clear_pend_q ? S_CLEAR : S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State and pending sweep flag; the tag RAM is swept right after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			clear_pend_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (set_pend) begin
				clear_pend_q <= 1'b1;
			end else if (state_d == S_CLEAR) begin
				clear_pend_q <= 1'b0;
			end
		end
	end

	// Fetch only follows a decision that issued a read
	a_fetch_after_read : assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FETCH) |-> ($past(state_q) == S_DECIDE && $past(cmd.rd_en)))
		else $error("fetch without a preceding read");

	// Result never overwrites a beat still held by the receiver
	a_no_overwrite : assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !stat.out_busy)
		else $error("output register loaded while stalled");

	// Sweep ends on the last entry and reopens the request side
	a_sweep_end : assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR && stat.clr_last) |=> (state_q == S_IDLE))
		else $error("clearing sweep did not end");

endmodule

### rtl/core/fbpa_dp.sv
// ----------------------------------------------------------------------------
// Fixed block pool allocator: datapath
// Configuration registers, request capture, used count, generation tag,
// address stack RAM, default address multiply/add and the output register.
// ----------------------------------------------------------------------------
module fbpa_dp #(
	parameter int CAPACITY      = fbpa_pkg::DEF_CAPACITY,
	parameter int ADDRESS_WIDTH = fbpa_pkg::DEF_ADDRESS_WIDTH
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_write_enable,
	input  logic [fbpa_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [fbpa_pkg::CFG_DATA_W-1:0]  cfg_write_data,
	input  logic [fbpa_pkg::OP_W-1:0]        operation,
	input  logic [fbpa_pkg::REL_W-1:0]       released_address,
	input  fbpa_pkg::dp_cmd_t                cmd,
	output fbpa_pkg::dp_stat_t               stat,
	output logic                             rsp_valid,
	input  logic                             rsp_stall,
	output logic [fbpa_pkg::OUT_W-1:0]       block_address,
	output logic [fbpa_pkg::STATUS_W-1:0]    status
);

	import fbpa_pkg::*;

	localparam int CNT_W  = $clog2(CAPACITY + 1);
	localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int EW     = (CNT_W > ENTRIES_W) ? CNT_W : ENTRIES_W;
	localparam int PROD_W = IDX_W + RCHUNK_W;
	localparam int RAM_W  = EPOCH_W + ADDRESS_WIDTH;

	logic [BASE_W-1:0]    base_q;
	logic [CHUNK_W-1:0]   chunk_q;
	logic [ENTRIES_W-1:0] entries_q;
	logic [MODE_W-1:0]    mode_q;

	op_t                  op_q;
	logic [REL_W-1:0]     rel_q;

	logic [CNT_W-1:0]     cnt_q;
	logic [CNT_W-1:0]     cnt_dec;
	logic [EPOCH_W-1:0]   epoch_q;
	logic [IDX_W-1:0]     clr_idx_q;

	logic [RCHUNK_W-1:0]  rchunk;
	logic [EW-1:0]        n_eff;
	logic [IDX_W-1:0]     rd_idx;
	logic [IDX_W-1:0]     push_idx;
	logic [PROD_W-1:0]    prod_q;

	logic                 ram_we;
	logic [IDX_W-1:0]     ram_waddr;
	logic [RAM_W-1:0]     ram_wdata;
	logic [RAM_W-1:0]     ram_rdata;

	logic                     tag_hit;
	logic [ADDRESS_WIDTH-1:0] dflt_addr;
	logic [ADDRESS_WIDTH-1:0] sel_addr;

	status_t              res_status_q;
	logic [OUT_W-1:0]     res_addr_q;
	logic                 out_valid_q;
	logic [OUT_W-1:0]     out_addr_q;
	status_t              out_status_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q    <= BASE_RST;
			chunk_q   <= CHUNK_RST;
			entries_q <= ENTRIES_RST;
			mode_q    <= MODE_RST;
		end else if (cfg_write_enable) begin
			unique case (cfg_index)
				CFG_BASE:    base_q    <= cfg_write_data[BASE_W-1:0];
				CFG_CHUNK:   chunk_q   <= cfg_write_data[CHUNK_W-1:0];
				CFG_ENTRIES: entries_q <= cfg_write_data[ENTRIES_W-1:0];
				CFG_MODE:    mode_q    <= cfg_write_data[MODE_W-1:0];
			endcase
		end
	end

	// Request capture
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			op_q  <= op_t'(operation);
			rel_q <= released_address;
		end
	end

	// Derived configuration: chunk rounded up to a multiple of 4, entries clamped to capacity
	assign rchunk = (RCHUNK_W'(chunk_q) + CHUNK_ALIGN_ADD) & CHUNK_ALIGN_MASK;
	assign n_eff  = (EW'(entries_q) > EW'(CAPACITY)) ? EW'(CAPACITY) : EW'(entries_q);

	// Used count
	assign cnt_dec = cnt_q - CNT_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.cnt_clear) begin
			cnt_q <= '0;
		end else if (cmd.cnt_one) begin
			cnt_q <= CNT_W'(1);
		end else if (cmd.cnt_inc) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end else if (cmd.wr_push) begin
			cnt_q <= cnt_dec;
		end
	end

	// Generation tag and clearing sweep index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			epoch_q   <= EPOCH_FIRST;
			clr_idx_q <= '0;
		end else begin
			if (cmd.epoch_next) begin
				epoch_q <= (epoch_q == EPOCH_LAST) ? EPOCH_FIRST : epoch_q + EPOCH_W'(1);
			end
			if (cmd.clr_write) begin
				clr_idx_q <= stat.clr_last ? '0 : clr_idx_q + IDX_W'(1);
			end
		end
	end

	// Stack RAM: tag plus address; tag zero marks an entry as never written
	assign rd_idx    = cmd.rd_zero ? '0 : cnt_q[IDX_W-1:0];
	assign push_idx  = cnt_dec[IDX_W-1:0];
	assign ram_we    = cmd.clr_write | cmd.wr_push;
	assign ram_waddr = cmd.clr_write ? clr_idx_q : push_idx;
	assign ram_wdata = cmd.clr_write ? '0 : {epoch_q, ADDRESS_WIDTH'(rel_q)};

	fbpa_ram #(
		.WIDTH (RAM_W),
		.DEPTH (CAPACITY)
	) u_stack (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (cmd.rd_en),
		.raddr (rd_idx),
		.rdata (ram_rdata)
	);

	// Default address: index * chunk registered, base added in the fetch cycle
	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			prod_q <= PROD_W'(rd_idx) * PROD_W'(rchunk);
		end
	end

	assign tag_hit   = (ram_rdata[RAM_W-1 -: EPOCH_W] == epoch_q);
	assign dflt_addr = ADDRESS_WIDTH'(base_q) + ADDRESS_WIDTH'(prod_q);
	assign sel_addr  = tag_hit ? ram_rdata[ADDRESS_WIDTH-1:0] : dflt_addr;

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.res_set) begin
			res_status_q <= cmd.res_status;
			res_addr_q   <= '0;
		end else if (cmd.res_addr_load) begin
			res_addr_q <= OUT_W'(sel_addr);
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !rsp_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_addr_q   <= res_addr_q;
			out_status_q <= res_status_q;
		end
	end

	assign rsp_valid     = out_valid_q;
	assign block_address = out_addr_q;
	assign status        = out_status_q;

	// Status toward the controller
	assign stat.op           = op_q;
	assign stat.alloc_unconf = (rchunk == '0) || (n_eff == '0);
	assign stat.alloc_avail  = (EW'(cnt_q) < n_eff);
	assign stat.loop_mode    = (mode_q == MODE_LOOP);
	assign stat.rel_null     = (rel_q == '0);
	assign stat.count_zero   = (cnt_q == '0);
	assign stat.epoch_last   = (epoch_q == EPOCH_LAST);
	assign stat.clr_last     = (clr_idx_q == IDX_W'(CAPACITY - 1));
	assign stat.out_busy     = out_valid_q && rsp_stall;

	// Count never runs past the pool
	a_cnt_bound : assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q <= CNT_W'(CAPACITY)))
		else $error("used count above capacity");

	// Live tag is never the never-written mark
	a_epoch_nonzero : assert property (@(posedge clk) disable iff (!arst_n)
		(epoch_q != '0))
		else $error("generation tag reached zero");

	// A push lowers the count by exactly one
	a_push_dec : assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_push |=> (cnt_q == $past(cnt_dec)))
		else $error("push did not decrement the count");

endmodule

### rtl/core/fixed_block_pool_allocator_top.sv
// ----------------------------------------------------------------------------
// Fixed block pool allocator: top level
// Pool of fixed-size blocks kept as a stack of block addresses with a used
// count; allocate pops, release pushes, restart empties the pool.
// ----------------------------------------------------------------------------
// Requests are handled one at a time. An allocate that hands out an entry
// passes from the accepted request beat to the result beat through decide,
// stack RAM read and multiply, address select and output load; every other
// request goes through decide and output load only. The next request is
// taken in the cycle after the result is loaded, so a stalled result delays
// only the next one. The read and select steps come from the registered read
// of the address stack RAM and the index * chunk multiply before the base add.
// After reset, and after every 255th restart when the generation tag wraps,
// the block sweeps all CAPACITY entries of the stack RAM (1024 by default)
// with req_stall high; configuration writes are taken during the sweep.
module fixed_block_pool_allocator_top #(
	parameter int CAPACITY      = fbpa_pkg::DEF_CAPACITY,
	parameter int ADDRESS_WIDTH = fbpa_pkg::DEF_ADDRESS_WIDTH
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_write_enable,
	input  logic [fbpa_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [fbpa_pkg::CFG_DATA_W-1:0]  cfg_write_data,
	input  logic                             req_valid,
	output logic                             req_stall,
	input  logic [fbpa_pkg::OP_W-1:0]        operation,
	input  logic [fbpa_pkg::REL_W-1:0]       released_address,
	output logic                             rsp_valid,
	input  logic                             rsp_stall,
	output logic [fbpa_pkg::OUT_W-1:0]       block_address,
	output logic [fbpa_pkg::STATUS_W-1:0]    status
);

	import fbpa_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	fbpa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	fbpa_dp #(
		.CAPACITY      (CAPACITY),
		.ADDRESS_WIDTH (ADDRESS_WIDTH)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_write_enable (cfg_write_enable),
		.cfg_index        (cfg_index),
		.cfg_write_data   (cfg_write_data),
		.operation        (operation),
		.released_address (released_address),
		.cmd              (cmd),
		.stat             (stat),
		.rsp_valid        (rsp_valid),
		.rsp_stall        (rsp_stall),
		.block_address    (block_address),
		.status           (status)
	);

endmodule

### tb/sv/tb_fixed_block_pool_allocator_top.sv
// ----------------------------------------------------------------------------
// Fixed block pool allocator: self-checking testbench
// Drives allocate, release, restart and spare requests through the
// valid/stall channels under several pool settings and idling patterns. A
// scoreboard class keeps its own copy of the address stack, written marks
// and used count, predicts each reply and checks every reply beat in order.
// ----------------------------------------------------------------------------
module tb_fixed_block_pool_allocator_top;
	timeunit 1ns;
	timeprecision 1ps;

	import fbpa_pkg::*;

	localparam int CAPACITY = DEF_CAPACITY;

	// Pool modes other than loop; all of them behave as static
	localparam logic [MODE_W-1:0] MODE_STATIC  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_DYNAMIC = 2'd2;
	localparam logic [MODE_W-1:0] MODE_SPARE   = 2'd3;

	typedef struct packed {
		logic [OUT_W-1:0] addr;
		status_t          status;
	} pool_reply_t;

	// Pool predictor and in-order reply checker
	class pool_scoreboard;
		logic [BASE_W-1:0]    base;
		logic [CHUNK_W-1:0]   chunk;
		logic [ENTRIES_W-1:0] entries;
		logic [MODE_W-1:0]    mode;
		logic [REL_W-1:0]     stack [CAPACITY];
		bit                   written [CAPACITY];
		int unsigned          used;
		int unsigned          restarts;
		int                   errors;
		pool_reply_t          pool_replies [$];

		function new();
			base = BASE_RST;
			chunk = CHUNK_RST;
			entries = ENTRIES_RST;
			mode = MODE_RST;
			foreach (written[i]) written[i] = 1'b0;
			used = 0;
			restarts = 0;
			errors = 0;
		endfunction

		function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
			CFG_BASE: base = data[BASE_W-1:0];
			CFG_CHUNK: chunk = data[CHUNK_W-1:0];
			CFG_ENTRIES: entries = data[ENTRIES_W-1:0];
			default: mode = data[MODE_W-1:0];
			endcase
		endfunction

		// Block size rounded up to a word multiple, one bit wider than the register
		function logic [RCHUNK_W-1:0] rounded_chunk();
			return (RCHUNK_W'(chunk) + CHUNK_ALIGN_ADD) & CHUNK_ALIGN_MASK;
		endfunction

		// Stack entry, or the computed default address if never written
		function logic [OUT_W-1:0] fetch(int unsigned idx);
			if (idx >= CAPACITY)
				return '0;
			if (written[idx])
				return stack[idx];
			return base + OUT_W'(idx) * OUT_W'(rounded_chunk());
		endfunction

		function int pending();
			return pool_replies.size();
		endfunction

		// Accepted request beat: update the pool and queue the reply it causes
		function void note_request(op_t op, logic [REL_W-1:0] rel);
			pool_reply_t res;
			int unsigned n;
			res.addr = '0;
			res.status = ST_OK;
			n = (entries > CAPACITY) ? CAPACITY : entries;
			case (op)
			OP_ALLOC: begin
				if (rounded_chunk() == 0 || n == 0) begin
					res.status = ST_UNCONFIGURED;
				end else if (used < n) begin
					res.addr = fetch(used);
					used++;
				end else if (mode == MODE_LOOP) begin
					res.addr = fetch(0);
					used = 1;
					res.status = ST_WRAPPED;
				end else begin
					res.status = ST_EXHAUSTED;
				end
			end
			OP_RELEASE: begin
				if (rel == '0 || mode == MODE_LOOP) begin
					res.status = ST_IGNORED;
				end else if (used == 0) begin
					res.status = ST_UNDERFLOW;
				end else begin
					used--;
					if (used < CAPACITY) begin
						stack[used] = rel;
						written[used] = 1'b1;
					end
				end
			end
			OP_RESTART: begin
				used = 0;
				foreach (written[i]) written[i] = 1'b0;
				restarts++;
			end
			default: res.status = ST_IGNORED;
			endcase
			pool_replies.push_back(res);
		endfunction

		// Reply beat: compare with the oldest prediction
		function void check_reply(logic [OUT_W-1:0] addr, logic [STATUS_W-1:0] st);
			pool_reply_t want;
			if (pool_replies.size() == 0) begin
				$error("unexpected reply beat: block_address %h status %0d", addr, st);
				errors++;
				return;
			end
			want = pool_replies.pop_front();
			if (addr !== want.addr) begin
				$error("block_address mismatch: expected %h, got %h", want.addr, addr);
				errors++;
			end
			if (st !== want.status) begin
				$error("status mismatch: expected %0d, got %0d", want.status, st);
				errors++;
			end
		endfunction
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_write_enable = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_write_data = '0;
	logic                   req_valid = 1'b0;
	logic                   req_stall;
	logic [OP_W-1:0]        operation = '0;
	logic [REL_W-1:0]       released_address = '0;
	logic                   rsp_valid;
	logic                   rsp_stall = 1'b0;
	logic [OUT_W-1:0]       block_address;
	logic [STATUS_W-1:0]    status;

	pool_scoreboard score = new();

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit hold_start = 1'b0;
	int hold_left = 0;

	fixed_block_pool_allocator_top dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_write_enable (cfg_write_enable),
		.cfg_index        (cfg_index),
		.cfg_write_data   (cfg_write_data),
		.req_valid        (req_valid),
		.req_stall        (req_stall),
		.operation        (operation),
		.released_address (released_address),
		.rsp_valid        (rsp_valid),
		.rsp_stall        (rsp_stall),
		.block_address    (block_address),
		.status           (status)
	);

	always #10 clk = ~clk;

	// Reply side: check accepted beats, stall at random or for a long hold-off
	always @(posedge clk) begin
		if (rsp_valid && !rsp_stall)
			score.check_reply(block_address, status);
		if (hold_start) begin
			hold_left = 400;
			hold_start = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// Run limit
	initial begin
		#10_000_000;
		$display("Some tests failed");
		$finish;
	end

	function automatic op_t pick_op(int alloc_pct, int rel_pct, int restart_pct);
		int x;
		x = $urandom_range(99);
		if (x < alloc_pct)
			return OP_ALLOC;
		if (x < alloc_pct + rel_pct)
			return OP_RELEASE;
		if (x < alloc_pct + rel_pct + restart_pct)
			return OP_RESTART;
		return OP_NOP;
	endfunction

	// Null now and then, otherwise any address
	function automatic logic [REL_W-1:0] pick_release();
		if ($urandom_range(9) == 0)
			return '0;
		return $urandom();
	endfunction

	// One request beat, after a random gap with valid low
	task automatic send_request(input op_t op, input logic [REL_W-1:0] rel);
		int gap;
		gap = 0;
		while (gap < 40 && $urandom_range(99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		operation <= op;
		released_address <= rel;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		score.note_request(op, rel);
	endtask

	task automatic run_random(input int count, input int alloc_pct, input int rel_pct,
			input int restart_pct);
		repeat (count)
			send_request(pick_op(alloc_pct, rel_pct, restart_pct), pick_release());
	endtask

	// Drop valid, wait for every reply, then let the pipeline settle
	task automatic wait_idle(input int settle);
		req_valid <= 1'b0;
		while (score.pending() != 0)
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_write_enable <= 1'b1;
		cfg_index <= idx;
		cfg_write_data <= data;
		@(posedge clk);
		score.write_reg(idx, data);
	endtask

	// All four registers, with junk above the chunk, entries and mode fields
	task automatic configure(input logic [BASE_W-1:0] b, input logic [CHUNK_W-1:0] c,
			input logic [ENTRIES_W-1:0] e, input logic [MODE_W-1:0] m);
		write_reg(CFG_BASE, b);
		write_reg(CFG_CHUNK, {16'($urandom()), c});
		write_reg(CFG_ENTRIES, {21'($urandom()), e});
		write_reg(CFG_MODE, {30'($urandom()), m});
		cfg_write_enable <= 1'b0;
	endtask

	initial begin
		int n;
		int full_seen;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings: no entries, empty pool, null release, spare op, restart
		send_request(OP_ALLOC, 32'h0000_1000);
		send_request(OP_RELEASE, 32'h0000_1234);
		send_request(OP_RELEASE, 32'h0);
		send_request(OP_NOP, 32'hFFFF_FFFF);
		send_request(OP_RESTART, 32'h0);

		// Largest chunk near the top of the address space: addresses wrap
		wait_idle(6);
		configure(32'hFFFF_FFF0, 16'hFFFF, 11'd3, MODE_STATIC);
		repeat (4) send_request(OP_ALLOC, 32'h0);
		send_request(OP_RELEASE, 32'hFFFF_FFFF);
		send_request(OP_RELEASE, 32'h0000_0001);
		send_request(OP_ALLOC, 32'h0);
		send_request(OP_ALLOC, 32'h0);
		send_request(OP_RESTART, 32'h0);
		send_request(OP_ALLOC, 32'h0);

		// Zero chunk size
		wait_idle(6);
		configure($urandom(), 16'd0, 11'd4, MODE_STATIC);
		send_request(OP_ALLOC, 32'h0);

		// Loop mode wraps to entry 0; releases are ignored
		wait_idle(6);
		configure(32'h0000_0100, 16'd5, 11'd2, MODE_LOOP);
		repeat (4) send_request(OP_ALLOC, 32'h0);
		send_request(OP_RELEASE, 32'h0000_0040);

		// Entry count lowered below the used count
		wait_idle(6);
		configure(32'h0000_0100, 16'd1, 11'd1, MODE_STATIC);
		send_request(OP_ALLOC, 32'h0);
		wait_idle(6);
		configure(32'h0000_0100, 16'd1, 11'd1, MODE_LOOP);
		send_request(OP_ALLOC, 32'h0);

		// Sender mostly busy, receiver mostly stalled; small pools, spare mode
		wait_idle(6);
		send_idle_pct = 19;
		recv_idle_pct = 80;
		configure($urandom(), 16'($urandom_range(0, 40)), 11'($urandom_range(1, 8)), MODE_SPARE);
		run_random(120, 35, 25, 30);

		// Sender mostly idle, receiver mostly ready; loop mode
		wait_idle(6);
		send_idle_pct = 80;
		recv_idle_pct = 19;
		configure($urandom(), 16'($urandom()), 11'($urandom_range(1, 6)), MODE_LOOP);
		run_random(120, 40, 20, 30);

		// No idling: oversized entry count fills the whole stack; long reply hold-off
		wait_idle(6);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		configure($urandom(), 16'hFFFF, 11'd2047, MODE_DYNAMIC);
		hold_start = 1'b1;
		n = 0;
		full_seen = 0;
		while (full_seen < 20 && n < 1400) begin
			send_request(pick_op(98, 2, 0), pick_release());
			n++;
			if (score.used == CAPACITY)
				full_seen++;
		end

		// Restart-heavy traffic, enough to wrap the generation tag
		wait_idle(6);
		configure($urandom(), 16'($urandom_range(1, 64)), 11'($urandom_range(1, 4)), MODE_STATIC);
		while (score.restarts < 280)
			send_request(pick_op(20, 10, 70), pick_release());

		wait_idle(10);
		if (score.pending() != 0) begin
			$error("%0d predicted replies never arrived", score.pending());
			score.errors++;
		end
		if (score.errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
